[src/four_channel_pwm_timer_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the four-channel PWM timer
// Clocked, reset-qualified wrappers for same-cycle and next-cycle properties.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_PWM_TIMER_DEFINES_SVH
`define FOUR_CHANNEL_PWM_TIMER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fcpt_pkg.sv]
// ----------------------------------------------------------------------------
// fcpt_pkg
// Commands, register indexes, reset values and widths of the PWM timer.
// ----------------------------------------------------------------------------
package fcpt_pkg;

  localparam int unsigned CHANNELS_DEF = 4;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned POL_W   = 4;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned PCT_W   = 8;
  localparam int unsigned DUTY_W  = 7;            // clamped percent, 0..100
  localparam int unsigned PROD_W  = CNT_W + DUTY_W;

  localparam logic [PCT_W-1:0]  PCT_MAX = 8'd100;

  // x / 25 == (x * RECIP_25) >> RECIP_SH for x below 2**21
  localparam int unsigned       QIN_W    = PROD_W - 2;
  localparam int unsigned       RECIP_W  = 22;
  localparam int unsigned       RECIP_SH = 26;
  localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;

  localparam logic [CNT_W-1:0] PRESCALE_RST = 16'd71;
  localparam logic [CNT_W-1:0] PERIOD_RST   = 16'd1181;
  localparam logic [POL_W-1:0] POLARITY_RST = 4'd1;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_DUTY    = 2'd1,
    CMD_ENABLE  = 2'd2,
    CMD_DISABLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PRESCALE = 2'd0,
    REG_PERIOD   = 2'd1,
    REG_POLARITY = 2'd2
  } reg_idx_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CH_W-1:0]   channel;
    logic [PROD_W-1:0] product;   // period * clamped percent
  } s1_item_t;

endpackage

[src/four_channel_pwm_timer.sv]
// ----------------------------------------------------------------------------
// four_channel_pwm_timer
// Edge-aligned four-channel PWM timer driven by a stream of commands.
// ----------------------------------------------------------------------------
// Flow: an accepted request is held in the request register; when it advances,
//   it updates the state and its result is registered in the result register.
// Throughput: one request per cycle while out_tready is high; the request
//   register feeds the state update and the result register in a single pass.
// Reset (rst_n low, synchronous): counters, compares, run and flag cleared;
//   registers back to prescale 71, period 1181, polarity 1; pipeline empty.
`include "four_channel_pwm_timer_defines.svh"

module four_channel_pwm_timer #(
  parameter int unsigned CHANNELS = fcpt_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] channel, [10:3] percent, [15:11] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] pwm_levels, [19:4] count_value,
                                  // [20] update_flag, [21] interrupt_request,
                                  // [23:22] zero
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import fcpt_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers; writes are always taken.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] prescale_r;
  logic [CNT_W-1:0] period_r;
  logic [POL_W-1:0] polarity_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_RST;
      period_r   <= PERIOD_RST;
      polarity_r <= POLARITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRESCALE: prescale_r <= cfg_data;
        REG_PERIOD:   period_r   <= cfg_data;
        REG_POLARITY: polarity_r <= cfg_data[POL_W-1:0];
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. The request register advances into the result
  // register whenever the result register is empty or being drained, so a
  // new request is still taken while a result waits if the request register is empty.
  // --------------------------------------------------------------------------
  logic s1_v_r;
  logic out_v_r;
  logic advance;
  logic s1_fire;

  assign advance   = !out_v_r || out_tready;
  assign s1_fire   = s1_v_r && advance;
  assign in_tready = !s1_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) s1_v_r <= in_tvalid;
      if (advance)   out_v_r <= s1_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Request register. Clamp the percent and form period * percent here, so
  // the next stage only has the divide by 100 left.
  // --------------------------------------------------------------------------
  s1_item_t          s1_r;
  logic [PCT_W-1:0]  pct_in;
  logic [DUTY_W-1:0] duty_in;

  assign pct_in  = in_tdata[CH_W +: PCT_W];
  assign duty_in = (pct_in > PCT_MAX) ? PCT_MAX[DUTY_W-1:0] : pct_in[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_r.cmd     <= cmd_t'(in_tuser);
      s1_r.channel <= in_tdata[CH_W-1:0];
      s1_r.product <= PROD_W'(period_r) * PROD_W'(duty_in);
    end
  end

  // --------------------------------------------------------------------------
  // Divide by 100: drop two bits, then multiply by the reciprocal of 25.
  // --------------------------------------------------------------------------
  logic [QIN_W-1:0]         q_in;
  logic [QIN_W+RECIP_W-1:0] q_prod;
  logic [CNT_W-1:0]         duty_cmp;

  assign q_in     = s1_r.product[PROD_W-1:2];
  assign q_prod   = (QIN_W+RECIP_W)'(q_in) * (QIN_W+RECIP_W)'(RECIP_25);
  assign duty_cmp = q_prod[RECIP_SH +: CNT_W];

  // --------------------------------------------------------------------------
  // Timer state and its next value for the request in the request register.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] pre_cnt_r,  pre_cnt_nxt;
  logic [CNT_W-1:0] main_cnt_r, main_cnt_nxt;
  logic [CNT_W-1:0] cmp_r   [CHANNELS];
  logic [CNT_W-1:0] cmp_nxt [CHANNELS];
  logic             running_r, running_nxt;
  logic             wrap_r,    wrap_nxt;

  always_comb begin
    pre_cnt_nxt  = pre_cnt_r;
    main_cnt_nxt = main_cnt_r;
    running_nxt  = running_r;
    wrap_nxt     = wrap_r;
    for (int i = 0; i < CHANNELS; i++) cmp_nxt[i] = cmp_r[i];

    case (s1_r.cmd)
      CMD_TICK: begin
        // While running, advance the prescaler; on its rollover step or wrap the counter.
        if (running_r) begin
          if (pre_cnt_r >= prescale_r) begin
            pre_cnt_nxt = '0;
            if (main_cnt_r >= period_r) begin
              main_cnt_nxt = '0;
              wrap_nxt     = 1'b1;
            end else begin
              main_cnt_nxt = main_cnt_r + 1'b1;
            end
          end else begin
            pre_cnt_nxt = pre_cnt_r + 1'b1;
          end
        end
      end
      CMD_DUTY: begin
        // Channels outside 1..CHANNELS match nothing and are ignored.
        for (int i = 0; i < CHANNELS; i++) begin
          if (s1_r.channel == CH_W'(i + 1)) cmp_nxt[i] = duty_cmp;
        end
      end
      CMD_ENABLE: begin
        wrap_nxt    = 1'b0;
        running_nxt = 1'b1;
      end
      default: begin
        // Disable: stop, clear the flag and zero every compare.
        wrap_nxt    = 1'b0;
        running_nxt = 1'b0;
        for (int i = 0; i < CHANNELS; i++) cmp_nxt[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_cnt_r  <= '0;
      main_cnt_r <= '0;
      running_r  <= 1'b0;
      wrap_r     <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) cmp_r[i] <= '0;
    end else if (s1_fire) begin
      pre_cnt_r  <= pre_cnt_nxt;
      main_cnt_r <= main_cnt_nxt;
      running_r  <= running_nxt;
      wrap_r     <= wrap_nxt;
      for (int i = 0; i < CHANNELS; i++) cmp_r[i] <= cmp_nxt[i];
    end
  end

  // --------------------------------------------------------------------------
  // Result: PWM mode 1 on the updated state, then apply polarity. Channels
  // past CHANNELS hold their level bit at zero.
  // --------------------------------------------------------------------------
  logic [POL_W-1:0] levels;
  logic [23:0]      out_data_r;

  always_comb begin
    levels = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      levels[i] = (main_cnt_nxt < cmp_nxt[i]) ^ polarity_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {2'b00, wrap_nxt && running_nxt, wrap_nxt, main_cnt_nxt, levels};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_disable_clears, s1_fire && s1_r.cmd == CMD_DISABLE,
               !running_r && !wrap_r && cmp_r[0] == '0, "disable left timer armed")
  `ASSERT_NEXT(a_enable_starts, s1_fire && s1_r.cmd == CMD_ENABLE,
               running_r && !wrap_r, "enable did not start the timer")
  `ASSERT_NEXT(a_stopped_holds, !running_r,
               $stable(main_cnt_r) && $stable(pre_cnt_r), "counter moved while stopped")
  `ASSERT_SAME(a_result_drained, $fell(out_tvalid), $past(out_tready),
               "result dropped without being taken")

endmodule
